// File: hw/rtl/assert_macros.svh
// assertion helper macros used by tea_variant_block_decrypt
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/tvbd_pkg.sv
// shared types and constants for the tea variant block decrypt
// no dependencies
`default_nettype none

package tvbd_pkg;

   localparam int WORD_WIDTH = 32;
   localparam logic [WORD_WIDTH-1:0] ROUND_DELTA = 32'h6745_2301;
   localparam int CSR_INDEX_WIDTH = 2;

   // csr register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      KEY_WORD0_INDEX = 2'd0,
      KEY_WORD1_INDEX = 2'd1,
      KEY_WORD2_INDEX = 2'd2,
      KEY_WORD3_INDEX = 2'd3
   } csr_index_type;

   // the four key words as one group
   typedef struct packed {
      logic [WORD_WIDTH-1:0] word0;
      logic [WORD_WIDTH-1:0] word1;
      logic [WORD_WIDTH-1:0] word2;
      logic [WORD_WIDTH-1:0] word3;
   } key_type;

endpackage

`default_nettype wire

// File: hw/rtl/tvbd_round.sv
// one registered decryption round of the tea variant pipeline
// depends on tvbd_pkg
`default_nettype none

module tvbd_round
   import tvbd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire key_type               key,
   input  wire logic [WORD_WIDTH-1:0] round_sum,
   input  wire logic                  up_valid,
   input  wire logic [WORD_WIDTH-1:0] up_left,
   input  wire logic [WORD_WIDTH-1:0] up_right,
   output logic                       down_valid,
   output logic [WORD_WIDTH-1:0]      down_left,
   output logic [WORD_WIDTH-1:0]      down_right
);

   // tea mixing function
   function automatic logic [WORD_WIDTH-1:0] mix(
      input logic [WORD_WIDTH-1:0] x,
      input logic [WORD_WIDTH-1:0] sum,
      input logic [WORD_WIDTH-1:0] ka,
      input logic [WORD_WIDTH-1:0] kb
   );
      return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
   endfunction

   logic                  valid_ff, valid_in;
   logic [WORD_WIDTH-1:0] left_ff, left_in;
   logic [WORD_WIDTH-1:0] right_ff, right_in;

   // right half first, then left half from the new right half
   always_comb begin
      valid_in = up_valid;
      right_in = up_right - mix(up_left, round_sum, key.word2, key.word3);
      left_in  = up_left - mix(right_in, round_sum, key.word0, key.word1);
   end

   // stage valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_left  = left_ff;
   assign down_right = right_ff;

endmodule

`default_nettype wire

// File: hw/rtl/tea_variant_block_decrypt.sv
// tea variant block decrypt: one round per pipeline stage, ROUND_COUNT stages
// a request passes through the stage registers in order from accept to result valid
// throughput: one block per cycle without stalls; a round is two mix and subtract steps
// a stalled result holds full stages with no gap after them; empty stages still fill
// reset (synchronous, active high) clears key words and all stage valid bits
// depends on tvbd_pkg, tvbd_round and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module tea_variant_block_decrypt
   import tvbd_pkg::*;
#(
   parameter int ROUND_COUNT = 35
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [WORD_WIDTH-1:0]      csr_write_data,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [WORD_WIDTH-1:0]      req_cipher_left,
   input  wire logic [WORD_WIDTH-1:0]      req_cipher_right,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [WORD_WIDTH-1:0]           rsp_plain_left,
   output logic [WORD_WIDTH-1:0]           rsp_plain_right
);

   key_type key_ff;

   // key word registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            KEY_WORD0_INDEX: key_ff.word0 <= csr_write_data;
            KEY_WORD1_INDEX: key_ff.word1 <= csr_write_data;
            KEY_WORD2_INDEX: key_ff.word2 <= csr_write_data;
            KEY_WORD3_INDEX: key_ff.word3 <= csr_write_data;
            default: ;
         endcase
      end
   end

   // stage links: index 0 is the request side, ROUND_COUNT the result side
   logic                  stage_valid [ROUND_COUNT+1];
   logic [WORD_WIDTH-1:0] stage_left  [ROUND_COUNT+1];
   logic [WORD_WIDTH-1:0] stage_right [ROUND_COUNT+1];
   logic                  stage_ready [ROUND_COUNT+1];

   assign stage_valid[0] = req_valid;
   assign stage_left[0]  = req_cipher_left;
   assign stage_right[0] = req_cipher_right;
   assign stage_ready[ROUND_COUNT] = rsp_ready;

   // one round per stage, sum counts down from delta times rounds
   for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
      localparam logic [63:0] SUM_WIDE = 64'(ROUND_DELTA) * 64'(ROUND_COUNT - r);
      localparam logic [WORD_WIDTH-1:0] ROUND_SUM = SUM_WIDE[WORD_WIDTH-1:0];

      // a stage takes new data when empty or when it passes its own on
      assign stage_ready[r] = !stage_valid[r+1] || stage_ready[r+1];

      tvbd_round u_round (
         .clock      (clock),
         .reset      (reset),
         .advance    (stage_ready[r]),
         .key        (key_ff),
         .round_sum  (ROUND_SUM),
         .up_valid   (stage_valid[r]),
         .up_left    (stage_left[r]),
         .up_right   (stage_right[r]),
         .down_valid (stage_valid[r+1]),
         .down_left  (stage_left[r+1]),
         .down_right (stage_right[r+1])
      );
   end

   assign req_ready       = stage_ready[0];
   assign rsp_valid       = stage_valid[ROUND_COUNT];
   assign rsp_plain_left  = stage_left[ROUND_COUNT];
   assign rsp_plain_right = stage_right[ROUND_COUNT];

   // a draining output frees the whole pipeline
   `ASSERT_IMPL(a_ready_when_draining, clock, reset, rsp_ready, req_ready,
      "request side stalled while result side drains")

   // an accepted request lands in the first stage
   `ASSERT_NEXT(a_accept_fills_first, clock, reset, req_valid && req_ready,
      stage_valid[1], "accepted request lost at first stage")

   // a full first stage that is held keeps its block
   `ASSERT_NEXT(a_first_stage_holds, clock, reset, stage_valid[1] && !stage_ready[1],
      stage_valid[1] && $stable(stage_left[1]) && $stable(stage_right[1]),
      "held first stage changed")

endmodule

`default_nettype wire

// File: test/tea_variant_block_decrypt_tb.sv
// testbench for tea_variant_block_decrypt: decrypts blocks under several key settings
// and checks each result against a built-in predictor of the 35-round network
// depends on tvbd_pkg and the tea_variant_block_decrypt rtl

module tea_variant_block_decrypt_tb;
   import tvbd_pkg::*;

   localparam int ROUND_COUNT = 35;
   localparam int RANDOM_PHASES = 6;
   localparam int BLOCKS_PER_PHASE = 90;
   localparam int DIRECTED_COUNT = 10;

   typedef logic [WORD_WIDTH-1:0] word_t;

   typedef struct packed {
      word_t left;
      word_t right;
   } cipher_block_t;

   typedef struct packed {
      word_t left;
      word_t right;
   } plain_block_t;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   word_t                      csr_write_data = '0;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   word_t                      req_cipher_left = '0;
   word_t                      req_cipher_right = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   word_t                      rsp_plain_left;
   word_t                      rsp_plain_right;

   // predictor state: key copy, pending requests and expected plaintext
   key_type       key_copy = '0;
   cipher_block_t pending_cipher_blocks[$];
   plain_block_t  expected_plain_blocks[$];
   int            sender_idle_pct = 0;
   int            receiver_idle_pct = 0;
   int            mismatch_count = 0;

   tea_variant_block_decrypt #(
      .ROUND_COUNT(ROUND_COUNT)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cipher_left  (req_cipher_left),
      .req_cipher_right (req_cipher_right),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_plain_left   (rsp_plain_left),
      .rsp_plain_right  (rsp_plain_right)
   );

   // clock, period 2
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // one half-round mixing term
   function automatic word_t tea_mix(word_t x, word_t sum, word_t ka, word_t kb);
      return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
   endfunction

   // full decryption under the current key copy
   function automatic plain_block_t decrypt_block(word_t left, word_t right);
      word_t        sum;
      plain_block_t plain;
      sum = ROUND_DELTA * ROUND_COUNT;
      for (int r = 0; r < ROUND_COUNT; r++) begin
         right -= tea_mix(left, sum, key_copy.word2, key_copy.word3);
         left -= tea_mix(right, sum, key_copy.word0, key_copy.word1);
         sum -= ROUND_DELTA;
      end
      plain.left = left;
      plain.right = right;
      return plain;
   endfunction

   // random word, biased toward the extremes
   function automatic word_t random_word();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   // one csr write, mirrored in the key copy
   task automatic write_key_word(input csr_index_type index, input word_t data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      case (index)
         KEY_WORD0_INDEX: key_copy.word0 = data;
         KEY_WORD1_INDEX: key_copy.word1 = data;
         KEY_WORD2_INDEX: key_copy.word2 = data;
         KEY_WORD3_INDEX: key_copy.word3 = data;
         default: ;
      endcase
   endtask

   task automatic load_keys(input key_type keys);
      write_key_word(KEY_WORD0_INDEX, keys.word0);
      write_key_word(KEY_WORD1_INDEX, keys.word1);
      write_key_word(KEY_WORD2_INDEX, keys.word2);
      write_key_word(KEY_WORD3_INDEX, keys.word3);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // block until no request is queued, in flight or awaiting its result
   task automatic wait_until_idle();
      while (pending_cipher_blocks.size() != 0 || req_valid ||
             expected_plain_blocks.size() != 0)
         @(posedge clock);
   endtask

   // request driver: predicts on accept, then offers the next block or idles
   always @(posedge clock) begin : drive_requests
      cipher_block_t next_block;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_plain_blocks.push_back(decrypt_block(req_cipher_left, req_cipher_right));
         if (!req_valid || req_ready) begin
            if (pending_cipher_blocks.size() != 0 &&
                $urandom_range(99) >= sender_idle_pct) begin
               next_block = pending_cipher_blocks.pop_front();
               req_valid <= 1'b1;
               req_cipher_left <= next_block.left;
               req_cipher_right <= next_block.right;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: compares against the oldest expectation, stalls at random
   always @(posedge clock) begin : check_results
      plain_block_t want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_plain_blocks.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result left %h right %h",
                           $time, rsp_plain_left, rsp_plain_right);
            end else begin
               want = expected_plain_blocks.pop_front();
               if (rsp_plain_left !== want.left || rsp_plain_right !== want.right) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: mismatch expected left %h right %h, got left %h right %h",
                              $time, want.left, want.right, rsp_plain_left, rsp_plain_right);
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // stimulus: directed blocks under zero and all-ones keys, then random phases
   initial begin : stimulus
      cipher_block_t directed_blocks [DIRECTED_COUNT];
      key_type       key_settings [RANDOM_PHASES];
      cipher_block_t block;

      directed_blocks = '{
         '{32'h0000_0000, 32'h0000_0000},
         '{32'hFFFF_FFFF, 32'hFFFF_FFFF},
         '{32'h0000_0000, 32'hFFFF_FFFF},
         '{32'hFFFF_FFFF, 32'h0000_0000},
         '{32'h8000_0000, 32'h0000_0001},
         '{32'h0000_0001, 32'h8000_0000},
         '{32'h5555_5555, 32'hAAAA_AAAA},
         '{32'hAAAA_AAAA, 32'h5555_5555},
         '{32'h6745_2301, 32'hEFCD_AB89},
         '{32'h7FFF_FFFF, 32'hFFFF_FFFE}
      };
      key_settings[0] = {random_word(), random_word(), random_word(), random_word()};
      key_settings[1] = {32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
      key_settings[2] = {random_word(), random_word(), random_word(), random_word()};
      key_settings[3] = {32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000};
      key_settings[4] = {random_word(), random_word(), random_word(), random_word()};
      key_settings[5] = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part, sender idles 30 and receiver 60 in a hundred
      sender_idle_pct = 30;
      receiver_idle_pct = 60;
      for (int phase = 0; phase < 2; phase++) begin
         wait_until_idle();
         load_keys(phase == 0 ? key_type'('0) : key_type'('1));
         foreach (directed_blocks[i])
            pending_cipher_blocks.push_back(directed_blocks[i]);
      end

      // random part: idle pattern swaps after two phases, then stops
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_until_idle();
         load_keys(key_settings[phase]);
         if (phase < 2) begin
            sender_idle_pct = 30;
            receiver_idle_pct = 60;
         end else if (phase < 4) begin
            sender_idle_pct = 60;
            receiver_idle_pct = 30;
         end else begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end
         repeat (BLOCKS_PER_PHASE) begin
            block.left = random_word();
            block.right = random_word();
            pending_cipher_blocks.push_back(block);
         end
      end

      // drain, then keep clocking so that stray results can still show up
      wait_until_idle();
      repeat (ROUND_COUNT + 10) @(posedge clock);
      if (mismatch_count == 0 && expected_plain_blocks.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // watchdog
   initial begin
      #200000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/tvbd_pkg.sv
hw/rtl/tvbd_round.sv
hw/rtl/tea_variant_block_decrypt.sv
test/tea_variant_block_decrypt_tb.sv
